// File: rtl/core/bmp_pkg.sv
// Package for the binomial-mod-prime block: the modulus, the table size and the start-up states.
`default_nettype none
package bmp_pkg;

  localparam int unsigned MAX_SIZE = 1023;
  localparam int unsigned TBL_AW   = $clog2(MAX_SIZE + 1);
  localparam int unsigned ARG_W    = 10;
  localparam int unsigned RES_W    = 30;

  localparam logic [RES_W-1:0] PRIME     = 30'd1000000007;
  localparam logic [RES_W-1:0] PRIME_M2  = 30'd1000000005;
  localparam logic [63:0]      MU64      = (64'd1 << 60) / 64'd1000000007;
  // The Barrett reciprocal floor(2^60 / p) fits in 31 bits.
  localparam logic [30:0]      BARRETT_MU = MU64[30:0];

  // Pipeline depth of the modular multiplier.
  localparam int unsigned MM_LAT = 5;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_FAC,
    ST_POW,
    ST_INV,
    ST_DONE
  } build_state_t;

endpackage
`default_nettype wire

// File: rtl/core/bmp_mulmod.sv
// Five-stage pipelined multiplier modulo the prime, with Barrett reduction.
`default_nettype none
module bmp_mulmod (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic                      in_v,
  input  wire logic [bmp_pkg::RES_W-1:0] op_a,
  input  wire logic [bmp_pkg::RES_W-1:0] op_b,
  output logic                           out_v,
  output logic [bmp_pkg::RES_W-1:0]      res
);
  import bmp_pkg::*;

  logic [MM_LAT-1:0] v_r;
  logic [59:0] prod1_r;
  logic [31:0] x2_r;
  logic [61:0] qm2_r;
  logic [31:0] x3_r;
  logic [31:0] qp3_r;
  logic [31:0] r4_r;
  logic [RES_W-1:0] r5_r;

  logic [30:0] q1;
  logic [30:0] q3;
  logic [31:0] p32;
  logic [31:0] p2x;
  logic [63:0] qp_full;

  assign q1      = prod1_r[59:29];
  assign q3      = qm2_r[61:31];
  assign p32     = {2'b00, PRIME};
  assign p2x     = {1'b0, PRIME, 1'b0};
  assign qp_full = 64'(q3) * 64'(PRIME);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[MM_LAT-2:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod1_r <= 60'(op_a) * 60'(op_b);
      x2_r    <= prod1_r[31:0];
      qm2_r   <= 62'(q1) * 62'(BARRETT_MU);
      x3_r    <= x2_r;
      qp3_r   <= qp_full[31:0];
      // The true remainder lies below three times the prime, so 32 bits hold it.
      r4_r    <= x3_r - qp3_r;
      if (r4_r >= p2x) begin
        r5_r <= RES_W'(r4_r - p2x);
      end else if (r4_r >= p32) begin
        r5_r <= RES_W'(r4_r - p32);
      end else begin
        r5_r <= RES_W'(r4_r);
      end
    end
  end

  assign out_v = v_r[MM_LAT-1];
  assign res   = r5_r;

endmodule
`default_nettype wire

// File: rtl/core/binomial_mod_prime_unit.sv
// Top level: binomial coefficient C(n,m) modulo 1000000007 from factorial tables.
// Requests arrive on in_valid/in_ready with in_set_size (n) and in_pick_count (m).
// Each request yields one result on out_valid/out_ready in out_binomial_mod,
// which is zero when m exceeds n.
// After reset a start-up sequence fills the factorial and inverse-factorial
// memories, using the first modular multiplier one operation at a time, and
// in_ready stays low until it is done.
// Once a request is accepted, the table read is registered at that edge, then
// two five-stage modular multipliers follow in series, and the last multiplier
// stage is the output register.
// Throughput is one request per cycle. When the receiver holds out_ready low
// with a result waiting, the whole pipeline holds and in_ready drops in the
// same cycle; nothing is lost or repeated.
`default_nettype none
module binomial_mod_prime_unit (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [bmp_pkg::ARG_W-1:0] in_set_size,
  input  wire logic [bmp_pkg::ARG_W-1:0] in_pick_count,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [bmp_pkg::RES_W-1:0]      out_binomial_mod
);
  import bmp_pkg::*;

  logic [RES_W-1:0] fac_mem [MAX_SIZE+1];
  logic [RES_W-1:0] inv_mem [MAX_SIZE+1];

  logic adv;
  logic done;
  logic in_acc;

  // Start-up sequencer.
  build_state_t     state_r, state_nxt;
  logic [RES_W-1:0] acc_r, acc_nxt;
  logic [RES_W-1:0] sq_r, sq_nxt;
  logic [RES_W-1:0] exp_r, exp_nxt;
  logic             ph_r, ph_nxt;
  logic [TBL_AW-1:0] i_r, i_nxt;
  logic             pend_r, pend_nxt;
  logic             seq_v;
  logic [RES_W-1:0] seq_a, seq_b;
  logic             fac_we, inv_we;
  logic [TBL_AW-1:0] fac_wa, inv_wa;
  logic [RES_W-1:0] fac_wd, inv_wd;

  // Query stage A: table reads.
  logic             va_r;
  logic             ok_r;
  logic [RES_W-1:0] fac_rd_r, invm_rd_r, invnm_rd_r;
  logic [ARG_W-1:0] diff;
  logic             ok_in;

  logic [RES_W-1:0] inv_dly_r [MM_LAT];

  logic             mm1_iv, mm1_ov, mm2_iv;
  logic [RES_W-1:0] mm1_a, mm1_b, mm1_res;

  assign done     = (state_r == ST_DONE);
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv && done;
  assign in_acc   = in_valid && in_ready;
  assign diff     = in_set_size - in_pick_count;
  assign ok_in    = (in_pick_count <= in_set_size) &&
                    (32'(in_set_size) <= 32'(MAX_SIZE));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    sq_r  <= sq_nxt;
    exp_r <= exp_nxt;
    ph_r  <= ph_nxt;
    i_r   <= i_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    sq_nxt    = sq_r;
    exp_nxt   = exp_r;
    ph_nxt    = ph_r;
    i_nxt     = i_r;
    pend_nxt  = pend_r;
    seq_v     = 1'b0;
    seq_a     = '0;
    seq_b     = '0;
    fac_we    = 1'b0;
    fac_wa    = '0;
    fac_wd    = '0;
    inv_we    = 1'b0;
    inv_wa    = '0;
    inv_wd    = '0;
    unique case (state_r)
      ST_INIT: begin
        fac_we    = 1'b1;
        fac_wd    = RES_W'(1);
        acc_nxt   = RES_W'(1);
        i_nxt     = TBL_AW'(1);
        pend_nxt  = 1'b0;
        state_nxt = ST_FAC;
      end
      ST_FAC: begin
        if (!pend_r) begin
          seq_v    = 1'b1;
          seq_a    = acc_r;
          seq_b    = RES_W'(i_r);
          pend_nxt = 1'b1;
        end else if (mm1_ov) begin
          fac_we   = 1'b1;
          fac_wa   = i_r;
          fac_wd   = mm1_res;
          acc_nxt  = mm1_res;
          pend_nxt = 1'b0;
          if (i_r == TBL_AW'(MAX_SIZE)) begin
            sq_nxt    = mm1_res;
            acc_nxt   = RES_W'(1);
            exp_nxt   = PRIME_M2;
            ph_nxt    = 1'b0;
            state_nxt = ST_POW;
          end else begin
            i_nxt = i_r + TBL_AW'(1);
          end
        end
      end
      ST_POW: begin
        // Square and multiply, low exponent bit first.
        if (!pend_r) begin
          if (exp_r == '0) begin
            inv_we    = 1'b1;
            inv_wa    = TBL_AW'(MAX_SIZE);
            inv_wd    = acc_r;
            i_nxt     = TBL_AW'(MAX_SIZE);
            state_nxt = ST_INV;
          end else if (!ph_r && !exp_r[0]) begin
            ph_nxt = 1'b1;
          end else begin
            seq_v    = 1'b1;
            seq_a    = ph_r ? sq_r : acc_r;
            seq_b    = sq_r;
            pend_nxt = 1'b1;
          end
        end else if (mm1_ov) begin
          pend_nxt = 1'b0;
          if (!ph_r) begin
            acc_nxt = mm1_res;
            ph_nxt  = 1'b1;
          end else begin
            sq_nxt  = mm1_res;
            exp_nxt = exp_r >> 1;
            ph_nxt  = 1'b0;
          end
        end
      end
      ST_INV: begin
        if (!pend_r) begin
          seq_v    = 1'b1;
          seq_a    = acc_r;
          seq_b    = RES_W'(i_r);
          pend_nxt = 1'b1;
        end else if (mm1_ov) begin
          inv_we   = 1'b1;
          inv_wa   = i_r - TBL_AW'(1);
          inv_wd   = mm1_res;
          acc_nxt  = mm1_res;
          pend_nxt = 1'b0;
          if (i_r == TBL_AW'(1)) begin
            state_nxt = ST_DONE;
          end else begin
            i_nxt = i_r - TBL_AW'(1);
          end
        end
      end
      ST_DONE: begin
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (fac_we) begin
      fac_mem[fac_wa] <= fac_wd;
    end
    if (inv_we) begin
      inv_mem[inv_wa] <= inv_wd;
    end
    if (adv) begin
      fac_rd_r   <= fac_mem[TBL_AW'(in_set_size)];
      invm_rd_r  <= inv_mem[TBL_AW'(in_pick_count)];
      invnm_rd_r <= inv_mem[TBL_AW'(diff)];
      ok_r       <= ok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_acc;
    end
  end

  // The third operand waits beside the first multiplier.
  always_ff @(posedge clk) begin
    if (adv) begin
      inv_dly_r[0] <= invnm_rd_r;
      for (int k = 1; k < MM_LAT; k++) begin
        inv_dly_r[k] <= inv_dly_r[k-1];
      end
    end
  end

  // A request with m above n gets a zero operand, so its product is zero.
  assign mm1_iv = done ? va_r : seq_v;
  assign mm1_a  = done ? (ok_r ? fac_rd_r : '0) : seq_a;
  assign mm1_b  = done ? invm_rd_r : seq_b;
  assign mm2_iv = mm1_ov && done;

  bmp_mulmod u_mm1 (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .in_v  (mm1_iv),
    .op_a  (mm1_a),
    .op_b  (mm1_b),
    .out_v (mm1_ov),
    .res   (mm1_res)
  );

  bmp_mulmod u_mm2 (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .in_v  (mm2_iv),
    .op_a  (mm1_res),
    .op_b  (inv_dly_r[MM_LAT-1]),
    .out_v (out_valid),
    .res   (out_binomial_mod)
  );

  a_ready_after_build: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> done) else $error("request taken before the tables were built");

  a_no_result_in_build: assert property (@(posedge clk) disable iff (!rst_n)
    !done |-> !out_valid) else $error("result produced during start-up");

  a_result_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_binomial_mod < PRIME)) else $error("result not reduced");

endmodule
`default_nettype wire
